// ===== sv/bfe_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfe_pkg
// Shared widths, operation codes, queue item type and the quarter-wave cosine
// table builder for the benchmark fitness evaluator.
// ----------------------------------------------------------------------------
package bfe_pkg;

    localparam int GENE_W         = 32;
    localparam int SUM_W          = 64;
    localparam int MODE_W         = 2;
    localparam int FRAC_BITS      = 16;
    localparam int COS_TABLE_BITS = 10;
    localparam int QSIZE          = 1 << COS_TABLE_BITS;
    localparam int COS_W          = FRAC_BITS + 1;
    localparam int CA_W           = COS_TABLE_BITS + 1;
    localparam int M2_W           = GENE_W + 1;
    localparam int SQ_W           = 2 * GENE_W;
    localparam int P2_W           = 2 * M2_W;
    localparam int T2_W           = P2_W - FRAC_BITS;
    localparam int A_W            = SQ_W - FRAC_BITS;
    localparam int D_W            = A_W + 1;
    localparam int LO_W           = (A_W + 1) / 2;
    localparam int HI_W           = A_W - LO_W;
    localparam int DSQ_W          = 2 * A_W;
    localparam int P_W            = (DSQ_W + 7 > SUM_W + FRAC_BITS + 1) ?
                                    DSQ_W + 7 : SUM_W + FRAC_BITS + 1;
    localparam int RAST_W         = FRAC_BITS + 6;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int NSTG           = 7;

    localparam logic [MODE_W-1:0] MODE_SPHERE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ROSEN  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RAST   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESET  = MODE_ROSEN;

    typedef logic [1:0] op_t;
    localparam op_t OP_SPHERE = 2'd0;
    localparam op_t OP_ROSEN  = 2'd1;
    localparam op_t OP_RAST   = 2'd2;
    localparam op_t OP_ZERO   = 2'd3;

    typedef struct packed {
        logic signed [GENE_W-1:0] gene;
        logic signed [GENE_W-1:0] prev;
        op_t                      op;
        logic                     last;
    } item_t;

    typedef logic [COS_W-1:0]     cos_val_t;
    typedef cos_val_t [QSIZE:0]   cos_rom_t;

    localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;
    localparam logic signed [63:0] ONE_Q30     = 64'sd1 << 30;
    localparam logic [9:1][8:0]    TAYLOR_DIV  = {9'd306, 9'd240, 9'd182, 9'd132, 9'd90,
                                                  9'd56, 9'd30, 9'd12, 9'd2};

    // cos(pi/2 * k / QSIZE) from a 9-term series in Q2.30, rounded to FRAC_BITS
    function automatic cos_rom_t build_cos_rom();
        cos_rom_t          rom;
        logic [63:0]       theta;
        logic [63:0]       t2;
        logic [63:0]       term;
        logic signed [63:0] acc;
        logic [63:0]       rnd;
        int                k;
        int                n;
        rom = '0;
        for (k = 0; k <= QSIZE; k++) begin
            theta = (HALF_PI_Q30 * 64'(k)) >> COS_TABLE_BITS;
            t2    = (theta * theta) >> 30;
            term  = 64'd1 << 30;
            acc   = signed'(term);
            for (n = 1; n <= 9; n++) begin
                term = ((term * t2) >> 30) / 64'(TAYLOR_DIV[n]);
                if (n % 2 == 1) begin
                    acc = acc - signed'(term);
                end else begin
                    acc = acc + signed'(term);
                end
            end
            if (acc < 0) begin
                acc = '0;
            end
            if (acc > ONE_Q30) begin
                acc = ONE_Q30;
            end
            rnd    = (unsigned'(acc) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
            rom[k] = rnd[COS_W-1:0];
        end
        return rom;
    endfunction

endpackage
`default_nettype wire

// ===== sv/bfe_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfe_front
// Accepts gene beats, holds the mode register and the previous gene, and
// tags each beat with the operation the back end has to carry out.
// ----------------------------------------------------------------------------
module bfe_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [bfe_pkg::MODE_W-1:0]    cfg_wr_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [bfe_pkg::GENE_W-1:0] s_gene,
    input  wire logic                          s_last,
    output logic                               push_valid,
    input  wire logic                          push_ready,
    output bfe_pkg::item_t                     push_item
);

    logic [bfe_pkg::MODE_W-1:0]        mode_reg;
    logic signed [bfe_pkg::GENE_W-1:0] prev_reg;
    logic                              have_prev_reg;
    logic                              accept;
    bfe_pkg::op_t                      op;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign accept     = s_valid && push_ready;

    always_comb begin
        case (mode_reg)
            bfe_pkg::MODE_ROSEN: begin
                op = have_prev_reg ? bfe_pkg::OP_ROSEN : bfe_pkg::OP_ZERO;
            end
            bfe_pkg::MODE_RAST: begin
                op = bfe_pkg::OP_RAST;
            end
            default: begin
                op = bfe_pkg::OP_SPHERE;
            end
        endcase
    end

    always_comb begin
        push_item.gene = s_gene;
        push_item.prev = prev_reg;
        push_item.op   = op;
        push_item.last = s_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= bfe_pkg::MODE_RESET;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            if (accept) begin
                prev_reg      <= s_gene;
                have_prev_reg <= !s_last;
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/bfe_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfe_queue
// Short FIFO of tagged beats between the front and the back end.
// ----------------------------------------------------------------------------
module bfe_queue (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire bfe_pkg::item_t in_item,
    output logic          out_valid,
    input  wire logic     out_pop,
    output bfe_pkg::item_t out_item
);

    localparam int PW = bfe_pkg::QPTR_W;
    localparam int DEPTH = bfe_pkg::QUEUE_DEPTH;

    bfe_pkg::item_t  mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW:0]     count_reg;
    logic            push;
    logic            pop;

    assign in_ready  = (count_reg != (PW + 1)'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== sv/bfe_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfe_back
// Seven-stage term pipeline (squares, cosine lookup, split Rosenbrock
// square, clipping) feeding a saturating accumulator and the result register.
// ----------------------------------------------------------------------------
module bfe_back (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire bfe_pkg::item_t             head,
    input  wire logic                       head_valid,
    output logic                            head_pop,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [bfe_pkg::SUM_W-1:0]       m_fitness,
    output logic                            m_saturated
);

    localparam int GW     = bfe_pkg::GENE_W;
    localparam int SW     = bfe_pkg::SUM_W;
    localparam int F      = bfe_pkg::FRAC_BITS;
    localparam int CTB    = bfe_pkg::COS_TABLE_BITS;
    localparam int CA_W   = bfe_pkg::CA_W;
    localparam int COS_W  = bfe_pkg::COS_W;
    localparam int M2_W   = bfe_pkg::M2_W;
    localparam int SQ_W   = bfe_pkg::SQ_W;
    localparam int P2_W   = bfe_pkg::P2_W;
    localparam int T2_W   = bfe_pkg::T2_W;
    localparam int A_W    = bfe_pkg::A_W;
    localparam int D_W    = bfe_pkg::D_W;
    localparam int LO_W   = bfe_pkg::LO_W;
    localparam int HI_W   = bfe_pkg::HI_W;
    localparam int HH_W   = 2 * HI_W;
    localparam int HL_W   = HI_W + LO_W;
    localparam int LL_W   = 2 * LO_W;
    localparam int DSQ_W  = bfe_pkg::DSQ_W;
    localparam int P_W    = bfe_pkg::P_W;
    localparam int RAST_W = bfe_pkg::RAST_W;
    localparam int NSTG   = bfe_pkg::NSTG;

    localparam bfe_pkg::cos_rom_t COS_ROM = bfe_pkg::build_cos_rom();
    localparam logic [M2_W-1:0]   ONE_M2  = M2_W'(1) << F;
    localparam logic [COS_W-1:0]  ONE_C   = COS_W'(1) << F;
    localparam logic [CA_W-1:0]   QSIZE_A = CA_W'(bfe_pkg::QSIZE);

    logic [NSTG:1] v_reg;
    logic          advance;

    // stage 1
    logic signed [GW-1:0]   x1_sel;
    logic [GW-1:0]          m1_c;
    logic signed [M2_W-1:0] dp_c;
    logic [M2_W-1:0]        m2_c;
    logic [GW-1:0]          ph_c;
    logic [CTB-1:0]         ci_c;
    logic [CA_W-1:0]        caddr_c;
    logic                   cneg_c;

    bfe_pkg::op_t           op1_reg;
    logic                   last1_reg;
    logic signed [GW-1:0]   xc1_reg;
    logic [GW-1:0]          m1_1_reg;
    logic [M2_W-1:0]        m2_1_reg;
    logic [CA_W-1:0]        caddr1_reg;
    logic                   cneg1_reg;

    // stage 2
    bfe_pkg::op_t           op2_reg;
    logic                   last2_reg;
    logic signed [GW-1:0]   xc2_reg;
    logic [SQ_W-1:0]        sq2_reg;
    logic [P2_W-1:0]        p2_2_reg;
    logic [COS_W-1:0]       cos2_reg;
    logic                   cneg2_reg;

    // stage 3
    logic [A_W-1:0]         a3_c;
    logic signed [D_W-1:0]  d3_c;
    logic [D_W-1:0]         dm3_abs;
    logic [COS_W:0]         om_c;
    logic [RAST_W-1:0]      rast_c;
    logic [SW-1:0]          simple3_c;

    bfe_pkg::op_t           op3_reg;
    logic                   last3_reg;
    logic [A_W-1:0]         dm3_reg;
    logic [T2_W-1:0]        t2_3_reg;
    logic [SW-1:0]          simple3_reg;

    // stage 4
    logic [HI_W-1:0]        dhi;
    logic [LO_W-1:0]        dlo;
    bfe_pkg::op_t           op4_reg;
    logic                   last4_reg;
    logic [HH_W-1:0]        hh4_reg;
    logic [HL_W-1:0]        hl4_reg;
    logic [LL_W-1:0]        ll4_reg;
    logic [T2_W-1:0]        t2_4_reg;
    logic [SW-1:0]          simple4_reg;

    // stage 5
    bfe_pkg::op_t           op5_reg;
    logic                   last5_reg;
    logic [DSQ_W-1:0]       dsq5_reg;
    logic [T2_W-1:0]        t2_5_reg;
    logic [SW-1:0]          simple5_reg;

    // stage 6
    logic [P_W-1:0]         p100_c;
    logic                   t1_ovf_c;
    bfe_pkg::op_t           op6_reg;
    logic                   last6_reg;
    logic [SW-1:0]          t1_6_reg;
    logic                   t1_ovf6_reg;
    logic [T2_W-1:0]        t2_6_reg;
    logic [SW-1:0]          simple6_reg;

    // stage 7
    logic [SW:0]            rs_c;
    logic [SW-1:0]          term_c;
    logic                   tovf_c;
    logic                   last7_reg;
    logic [SW-1:0]          term7_reg;
    logic                   tovf7_reg;

    // accumulator and result
    logic [SW:0]            acc_c;
    logic [SW-1:0]          sum_next;
    logic                   ovf_next;
    logic [SW-1:0]          sum_reg;
    logic                   ovf_reg;
    logic                   m_valid_reg;
    logic [SW-1:0]          fitness_reg;
    logic                   sat_reg;

    assign advance  = !(v_reg[NSTG] && last7_reg && m_valid_reg && !m_ready);
    assign head_pop = head_valid && advance;

    always_comb begin
        x1_sel  = (head.op == bfe_pkg::OP_ROSEN) ? head.prev : head.gene;
        m1_c    = x1_sel[GW-1] ? GW'(~x1_sel + 1'b1) : x1_sel;
        dp_c    = signed'({head.prev[GW-1], head.prev}) - signed'(ONE_M2);
        m2_c    = dp_c[M2_W-1] ? M2_W'(~dp_c + 1'b1) : dp_c;
        ph_c    = {head.gene[F-1:0], {(GW - F){1'b0}}};
        ci_c    = ph_c[GW-3 -: CTB];
        caddr_c = ph_c[GW-2] ? (QSIZE_A - {1'b0, ci_c}) : {1'b0, ci_c};
        cneg_c  = ph_c[GW-1] ^ ph_c[GW-2];
    end

    always_comb begin
        a3_c      = sq2_reg[SQ_W-1:F];
        d3_c      = signed'({1'b0, a3_c}) - D_W'(xc2_reg);
        dm3_abs   = d3_c[D_W-1] ? D_W'(~d3_c + 1'b1) : d3_c;
        om_c      = cneg2_reg ? ({1'b0, ONE_C} + {1'b0, cos2_reg})
                              : ({1'b0, ONE_C} - {1'b0, cos2_reg});
        rast_c    = RAST_W'({om_c, 3'b000}) + RAST_W'({om_c, 1'b0});
        simple3_c = SW'(a3_c) + ((op2_reg == bfe_pkg::OP_RAST) ? SW'(rast_c) : '0);
    end

    assign dhi = dm3_reg[A_W-1:LO_W];
    assign dlo = dm3_reg[LO_W-1:0];

    always_comb begin
        p100_c   = (P_W'(dsq5_reg) << 6) + (P_W'(dsq5_reg) << 5) + (P_W'(dsq5_reg) << 2);
        t1_ovf_c = |p100_c[P_W-1:SW+F];
    end

    always_comb begin
        rs_c = {1'b0, t1_6_reg} + (SW + 1)'(t2_6_reg);
        case (op6_reg)
            bfe_pkg::OP_ROSEN: begin
                term_c = rs_c[SW] ? '1 : rs_c[SW-1:0];
                tovf_c = t1_ovf6_reg || rs_c[SW];
            end
            bfe_pkg::OP_ZERO: begin
                term_c = '0;
                tovf_c = 1'b0;
            end
            default: begin
                term_c = simple6_reg;
                tovf_c = 1'b0;
            end
        endcase
    end

    always_comb begin
        acc_c    = {1'b0, sum_reg} + {1'b0, term7_reg};
        sum_next = acc_c[SW] ? '1 : acc_c[SW-1:0];
        ovf_next = ovf_reg || tovf7_reg || acc_c[SW];
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            op1_reg     <= head.op;
            last1_reg   <= head.last;
            xc1_reg     <= head.gene;
            m1_1_reg    <= m1_c;
            m2_1_reg    <= m2_c;
            caddr1_reg  <= caddr_c;
            cneg1_reg   <= cneg_c;

            op2_reg     <= op1_reg;
            last2_reg   <= last1_reg;
            xc2_reg     <= xc1_reg;
            sq2_reg     <= SQ_W'(m1_1_reg) * SQ_W'(m1_1_reg);
            p2_2_reg    <= P2_W'(m2_1_reg) * P2_W'(m2_1_reg);
            cos2_reg    <= COS_ROM[caddr1_reg];
            cneg2_reg   <= cneg1_reg;

            op3_reg     <= op2_reg;
            last3_reg   <= last2_reg;
            dm3_reg     <= dm3_abs[A_W-1:0];
            t2_3_reg    <= p2_2_reg[P2_W-1:F];
            simple3_reg <= simple3_c;

            op4_reg     <= op3_reg;
            last4_reg   <= last3_reg;
            hh4_reg     <= HH_W'(dhi) * HH_W'(dhi);
            hl4_reg     <= HL_W'(dhi) * HL_W'(dlo);
            ll4_reg     <= LL_W'(dlo) * LL_W'(dlo);
            t2_4_reg    <= t2_3_reg;
            simple4_reg <= simple3_reg;

            op5_reg     <= op4_reg;
            last5_reg   <= last4_reg;
            dsq5_reg    <= (DSQ_W'(hh4_reg) << (2 * LO_W)) + (DSQ_W'(hl4_reg) << (LO_W + 1))
                         + DSQ_W'(ll4_reg);
            t2_5_reg    <= t2_4_reg;
            simple5_reg <= simple4_reg;

            op6_reg     <= op5_reg;
            last6_reg   <= last5_reg;
            t1_6_reg    <= t1_ovf_c ? '1 : p100_c[SW+F-1:F];
            t1_ovf6_reg <= t1_ovf_c;
            t2_6_reg    <= t2_5_reg;
            simple6_reg <= simple5_reg;

            last7_reg   <= last6_reg;
            term7_reg   <= term_c;
            tovf7_reg   <= tovf_c;

            if (v_reg[NSTG] && last7_reg) begin
                fitness_reg <= sum_next;
                sat_reg     <= ovf_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg       <= '0;
            sum_reg     <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (advance && v_reg[NSTG] && last7_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (advance) begin
                v_reg <= {v_reg[NSTG-1:1], head_pop};
                if (v_reg[NSTG]) begin
                    if (last7_reg) begin
                        sum_reg     <= '0;
                        ovf_reg     <= 1'b0;
                    end else begin
                        sum_reg     <= sum_next;
                        ovf_reg     <= ovf_next;
                    end
                end
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_fitness   = fitness_reg;
    assign m_saturated = sat_reg;

`ifndef ASSERT_OFF
    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(v_reg[NSTG] && last7_reg && advance))
        else $error("result register loaded without a last beat");

    a_sat_is_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && sat_reg |-> &fitness_reg)
        else $error("saturated flag with an unclipped sum");

    a_term_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[NSTG] && tovf7_reg |-> &term7_reg)
        else $error("term overflow without a clipped term");

    a_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(v_reg))
        else $error("pipeline moved while stalled");
`endif

endmodule
`default_nettype wire

// ===== sv/benchmark_fitness_evaluator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// benchmark_fitness_evaluator_unit
// Sphere / Rosenbrock / Rastrigin objective over a stream of Q15.16 genes.
//
//   channel   dir  handshake            payload
//   s_        in   s_valid / s_ready    s_gene[31:0] signed, s_last
//   m_        out  m_valid / m_ready    m_fitness[63:0], m_saturated
//   cfg_      in   cfg_wr_en            cfg_wr_data[1:0] function mode
//
// One gene per cycle sustained unless a held result stalls the back end; m_valid
// rises after the last gene has gone through the queue and the seven term stages.
// Latency is set by the split Rosenbrock square in the term pipeline.
// Reset is synchronous; no clearing pass, the block is ready right after it.
// A held result stalls the back end only when the next last beat reaches the
// accumulator; the four-entry queue then fills and s_ready drops.
// ----------------------------------------------------------------------------
module benchmark_fitness_evaluator_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [bfe_pkg::MODE_W-1:0]    cfg_wr_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [bfe_pkg::GENE_W-1:0] s_gene,
    input  wire logic                          s_last,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [bfe_pkg::SUM_W-1:0]          m_fitness,
    output logic                               m_saturated
);

    bfe_pkg::item_t push_item;
    bfe_pkg::item_t head_item;
    logic           push_valid;
    logic           push_ready;
    logic           head_valid;
    logic           head_pop;

    bfe_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_gene      (s_gene),
        .s_last      (s_last),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_item   (push_item)
    );

    bfe_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_item   (push_item),
        .out_valid (head_valid),
        .out_pop   (head_pop),
        .out_item  (head_item)
    );

    bfe_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (head_item),
        .head_valid  (head_valid),
        .head_pop    (head_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_fitness   (m_fitness),
        .m_saturated (m_saturated)
    );

endmodule
`default_nettype wire

// ===== tb/sv/tb_benchmark_fitness_evaluator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_benchmark_fitness_evaluator_unit
// Self-checking bench for the sphere / Rosenbrock / Rastrigin evaluator.
// Gene beats are fed through the s_ handshake in random bursts while the m_
// side stalls on its own pattern. A fixed-point predictor tracks
// the running sum per vector and queues one expected fitness per last beat;
// every m_ beat is checked field by field against the oldest entry.
// ----------------------------------------------------------------------------
module tb_benchmark_fitness_evaluator_unit;

    localparam logic [bfe_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;

    localparam int RX_OPEN    = 0;
    localparam int RX_PATTERN = 1;
    localparam int RX_RANDOM  = 2;

    typedef struct {
        bit [bfe_pkg::SUM_W-1:0] fitness;
        bit                      saturated;
    } fitness_rec_t;

    logic                              aclk;
    logic                              aresetn;
    logic                              cfg_wr_en;
    logic [bfe_pkg::MODE_W-1:0]        cfg_wr_data;
    logic                              s_valid;
    logic                              s_ready;
    logic signed [bfe_pkg::GENE_W-1:0] s_gene;
    logic                              s_last;
    logic                              m_valid;
    logic                              m_ready;
    logic [bfe_pkg::SUM_W-1:0]         m_fitness;
    logic                              m_saturated;

    benchmark_fitness_evaluator_unit uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_gene      (s_gene),
        .s_last      (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_fitness   (m_fitness),
        .m_saturated (m_saturated)
    );

    // predictor state
    longint                     cos_quarter [0:bfe_pkg::QSIZE];
    logic [bfe_pkg::MODE_W-1:0] fit_mode;
    logic [bfe_pkg::GENE_W-1:0] prior_gene;
    bit                         prior_valid;
    bit [bfe_pkg::SUM_W-1:0]    partial_sum;
    bit                         sum_clipped;
    fitness_rec_t               pending_fitness [$];

    int error_count;
    int cycle_count;
    int burst_left;
    bit sender_steady;
    int rx_style;
    bit [7:0] rx_pattern;
    int hold_left;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // fixed-point predictor
    // ------------------------------------------------------------------
    function automatic bit [bfe_pkg::SUM_W-1:0] clip_add(bit [bfe_pkg::SUM_W-1:0] a,
                                                         bit [bfe_pkg::SUM_W-1:0] b);
        if (a > ~b) begin
            sum_clipped = 1'b1;
            return '1;
        end
        return a + b;
    endfunction

    function automatic bit [bfe_pkg::SUM_W-1:0] square_frac(longint v);
        bit [63:0] m;
        m = (v < 0) ? -v : v;
        return (m * m) >> bfe_pkg::FRAC_BITS;
    endfunction

    function automatic bit [bfe_pkg::SUM_W-1:0] pair_term(longint xp, longint xc);
        longint     a;
        longint     d;
        bit [63:0]  dm;
        bit [127:0] prod;
        bit [63:0]  t1;
        bit [63:0]  t2;
        a    = longint'(square_frac(xp));
        d    = a - xc;
        dm   = (d < 0) ? -d : d;
        prod = 128'(dm * 64'd100) * 128'(dm);
        if (prod[127:bfe_pkg::FRAC_BITS+64] != 0) begin
            sum_clipped = 1'b1;
            t1 = '1;
        end else begin
            t1 = prod[bfe_pkg::FRAC_BITS+63:bfe_pkg::FRAC_BITS];
        end
        t2 = square_frac(xp - (longint'(1) << bfe_pkg::FRAC_BITS));
        return clip_add(t1, t2);
    endfunction

    function automatic bit [bfe_pkg::SUM_W-1:0] rast_term(longint x);
        bit [63:0] ux;
        bit [31:0] ph;
        bit [1:0]  quad;
        int        idx;
        longint    c;
        ux   = x;
        ph   = 32'(ux[bfe_pkg::FRAC_BITS-1:0]) << (32 - bfe_pkg::FRAC_BITS);
        quad = ph[31:30];
        idx  = int'((ph >> (30 - bfe_pkg::COS_TABLE_BITS)) & (bfe_pkg::QSIZE - 1));
        case (quad)
            2'd0: c = cos_quarter[idx];
            2'd1: c = -cos_quarter[bfe_pkg::QSIZE-idx];
            2'd2: c = -cos_quarter[idx];
            default: c = cos_quarter[bfe_pkg::QSIZE-idx];
        endcase
        return square_frac(x) + 64'(10 * ((longint'(1) << bfe_pkg::FRAC_BITS) - c));
    endfunction

    function automatic void take_gene(logic signed [bfe_pkg::GENE_W-1:0] g, logic l);
        longint                  x;
        bit [bfe_pkg::SUM_W-1:0] term;
        fitness_rec_t            rec;
        x    = longint'(g);
        term = '0;
        case (fit_mode)
            bfe_pkg::MODE_ROSEN: begin
                if (prior_valid) begin
                    term = pair_term(longint'(signed'(prior_gene)), x);
                end
            end
            bfe_pkg::MODE_RAST: term = rast_term(x);
            default: term = square_frac(x);
        endcase
        partial_sum = clip_add(partial_sum, term);
        prior_gene  = g;
        prior_valid = 1'b1;
        if (l) begin
            rec.fitness   = partial_sum;
            rec.saturated = sum_clipped;
            pending_fitness.push_back(rec);
            partial_sum = '0;
            sum_clipped = 1'b0;
            prior_valid = 1'b0;
        end
    endfunction

    task automatic report(string what, bit [bfe_pkg::SUM_W-1:0] got,
                          bit [bfe_pkg::SUM_W-1:0] want);
        $display("mismatch %s at cycle %0d: got %h expected %h",
                 what, cycle_count, got, want);
        error_count++;
    endtask

    // handshake monitor: predict on accepted genes, check accepted results
    always @(posedge aclk) begin
        fitness_rec_t rec;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                take_gene(s_gene, s_last);
            end
            if (m_valid && m_ready) begin
                if (pending_fitness.size() == 0) begin
                    report("unexpected beat", m_fitness, '0);
                end else begin
                    rec = pending_fitness.pop_front();
                    if (m_fitness !== rec.fitness) begin
                        report("fitness", m_fitness, rec.fitness);
                    end
                    if (m_saturated !== rec.saturated) begin
                        report("saturated", 64'(m_saturated), 64'(rec.saturated));
                    end
                end
            end
        end
    end

    // result side stall generator; long hold-offs counted here
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            case (rx_style)
                RX_PATTERN: begin
                    m_ready    <= rx_pattern[0];
                    rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
                end
                RX_RANDOM: m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= 1'b1;
            endcase
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_beat(logic signed [bfe_pkg::GENE_W-1:0] g, logic l);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap        = sender_steady ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_gene  <= g;
        s_last  <= l;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_fitness.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // call only right after wait_idle
    task automatic write_mode(logic [bfe_pkg::MODE_W-1:0] m);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        fit_mode  = m;
    endtask

    task automatic pick_receiver();
        rx_style   = $urandom_range(RX_OPEN, RX_RANDOM);
        rx_pattern = 8'($urandom()) | 8'h01;
    endtask

    function automatic logic signed [bfe_pkg::GENE_W-1:0] pick_gene();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1: return $urandom();
            7, 8: return $urandom_range(0, 512 << bfe_pkg::FRAC_BITS)
                         - (256 << bfe_pkg::FRAC_BITS);
            9: begin
                case ($urandom_range(0, 7))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    3: return 32'h0001_0000;
                    4: return 32'hFFFF_0000;
                    5: return 32'h0000_FFFF;
                    6: return 32'h0000_0001;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom_range(0, 8 << bfe_pkg::FRAC_BITS)
                            - (4 << bfe_pkg::FRAC_BITS);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_rosenbrock_directed();
        // mode is still at its reset value here
        send_beat(32'h0000_0000, 1'b1);
        send_beat(32'h0001_0000, 1'b0);
        send_beat(32'h0001_0000, 1'b1);
        send_beat(32'h7FFF_FFFF, 1'b0);
        send_beat(32'h8000_0000, 1'b1);
        send_beat(32'hFFFF_0000, 1'b0);
        send_beat(32'h0002_0000, 1'b0);
        send_beat(32'hFFFF_FFFF, 1'b1);
    endtask

    task automatic test_sphere_directed();
        wait_idle();
        write_mode(bfe_pkg::MODE_SPHERE);
        send_beat(32'h8000_0000, 1'b0);
        send_beat(32'h7FFF_FFFF, 1'b0);
        send_beat(32'h0000_0001, 1'b0);
        send_beat(32'hFFFF_FFFF, 1'b1);
        wait_idle();
        write_mode(MODE_SPARE);
        send_beat(32'h0001_0000, 1'b0);
        send_beat(32'hFFFF_0000, 1'b1);
    endtask

    task automatic test_rastrigin_directed();
        wait_idle();
        write_mode(bfe_pkg::MODE_RAST);
        send_beat(32'h0000_0000, 1'b0);
        send_beat(32'h0000_4000, 1'b0);
        send_beat(32'h0000_8000, 1'b0);
        send_beat(32'h0000_C000, 1'b1);
        send_beat(32'h0000_FFFF, 1'b0);
        send_beat(32'hFFFE_3A10, 1'b0);
        send_beat(32'h8000_0000, 1'b0);
        send_beat(32'h7FFF_FFFF, 1'b1);
    endtask

    task automatic test_mode_switch_mid_vector();
        wait_idle();
        write_mode(bfe_pkg::MODE_SPHERE);
        send_beat(32'h0003_0000, 1'b0);
        send_beat(32'h0001_8000, 1'b0);
        wait_idle();
        write_mode(bfe_pkg::MODE_ROSEN);
        send_beat(32'h0002_0000, 1'b0);
        wait_idle();
        write_mode(bfe_pkg::MODE_RAST);
        send_beat(32'h0002_C000, 1'b1);
    endtask

    task automatic test_random_phase(logic [bfe_pkg::MODE_W-1:0] m, int beats,
                                     bit leave_open);
        int sent;
        int len;
        int i;
        wait_idle();
        write_mode(m);
        pick_receiver();
        sender_steady = ($urandom_range(0, 3) == 0);
        sent = 0;
        while (sent < beats) begin
            len = $urandom_range(1, 8);
            for (i = 0; i < len; i++) begin
                send_beat(pick_gene(), i == len - 1);
            end
            sent += len;
        end
        // an open vector carries over into the next mode
        if (leave_open && $urandom_range(0, 2) != 0) begin
            len = $urandom_range(1, 2);
            for (i = 0; i < len; i++) begin
                send_beat(pick_gene(), 1'b0);
            end
        end
    endtask

    task automatic test_backpressure();
        int v;
        wait_idle();
        write_mode(bfe_pkg::MODE_SPHERE);
        sender_steady = 1'b1;
        rx_style      = RX_OPEN;
        hold_left     = 300;
        for (v = 0; v < 40; v++) begin
            if ($urandom_range(0, 1) == 1) begin
                send_beat(pick_gene(), 1'b0);
            end
            send_beat(pick_gene(), 1'b1);
        end
        sender_steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        bit [63:0] theta;
        bit [63:0] t2;
        bit [63:0] term;
        longint    acc;
        int        k;
        int        n;

        aclk        = 1'b0;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_gene      = '0;
        s_last      = 1'b0;
        m_ready     = 1'b0;

        error_count   = 0;
        cycle_count   = 0;
        burst_left    = 0;
        sender_steady = 1'b0;
        rx_style      = RX_OPEN;
        rx_pattern    = 8'hFF;
        hold_left     = 0;

        fit_mode    = bfe_pkg::MODE_ROSEN;
        prior_gene  = '0;
        prior_valid = 1'b0;
        partial_sum = '0;
        sum_clipped = 1'b0;

        // quarter-wave cosine, 9-term series in Q2.30
        for (k = 0; k <= bfe_pkg::QSIZE; k++) begin
            theta = (64'd1686629713 * 64'(k)) >> bfe_pkg::COS_TABLE_BITS;
            t2    = (theta * theta) >> 30;
            term  = 64'd1 << 30;
            acc   = longint'(term);
            for (n = 1; n <= 9; n++) begin
                term = ((term * t2) >> 30) / 64'((2 * n - 1) * (2 * n));
                if (n % 2 == 1) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            if (acc > (longint'(1) << 30)) begin
                acc = longint'(1) << 30;
            end
            cos_quarter[k] = (acc + (longint'(1) << (29 - bfe_pkg::FRAC_BITS)))
                             >>> (30 - bfe_pkg::FRAC_BITS);
        end

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_rosenbrock_directed();
        test_sphere_directed();
        test_rastrigin_directed();
        test_mode_switch_mid_vector();

        test_random_phase(bfe_pkg::MODE_ROSEN,  70, 1'b1);
        test_random_phase(bfe_pkg::MODE_SPHERE, 70, 1'b1);
        test_random_phase(bfe_pkg::MODE_RAST,   70, 1'b1);
        test_random_phase(MODE_SPARE,           70, 1'b1);
        test_random_phase(bfe_pkg::MODE_RAST,   70, 1'b1);
        test_random_phase(bfe_pkg::MODE_ROSEN,  70, 1'b1);
        test_random_phase(bfe_pkg::MODE_SPHERE, 70, 1'b1);
        test_backpressure();
        test_random_phase(bfe_pkg::MODE_RAST,   70, 1'b0);

        wait_idle();
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
